// ----- design/spm_pkg.sv -----
// Shared constants, types and result layout for the sliding pattern matcher.
package spm_pkg;

	localparam int PATTERN_MAX = 16;
	localparam int TEXT_MAX    = 65536;

	localparam int SLOT_W  = 4;
	localparam int VALUE_W = 32;
	localparam int LEN_W   = 5;
	localparam int POS_W   = 16;
	localparam int CNT_W   = 16;
	localparam int IDX_W   = $clog2(TEXT_MAX + 1);
	localparam int PIDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	localparam int S_TDATA_W = ((SLOT_W + VALUE_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((POS_W + CNT_W + 7) / 8) * 8;

	localparam logic [POS_W-1:0] POS_SAT = '1;
	localparam logic [CNT_W-1:0] CNT_SAT = '1;

	localparam logic KIND_PATTERN = 1'b0;
	localparam logic KIND_TEXT    = 1'b1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic             is_done;
		logic [POS_W-1:0] match_position;
		logic [CNT_W-1:0] match_count;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

// ----- design/spm_out_fifo.sv -----
// Small result queue that takes up to two items per cycle and sends one per cycle while m_tready is high.
module spm_out_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  spm_pkg::push_t                 push,
	output logic                           room,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic                           m_tuser,  // is_done
	output logic [spm_pkg::M_TDATA_W-1:0]  m_tdata   // match_position, match_count
);
	import spm_pkg::*;

	result_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wr_ptr_q;
	logic [FIFO_AW-1:0]  rd_ptr_q;
	logic [FIFO_CW-1:0]  count_q;
	logic [FIFO_AW-1:0]  wr_ptr_nxt1;
	logic                pop;
	result_t             head;

	assign wr_ptr_nxt1 = wr_ptr_q + FIFO_AW'(1);
	assign pop         = m_tvalid && m_tready;
	assign room        = count_q <= FIFO_CW'(FIFO_DEPTH - 2);
	assign m_tvalid    = count_q != '0;
	assign head        = mem_q[rd_ptr_q];
	assign m_tuser     = head.is_done;
	assign m_tdata     = M_TDATA_W'({head.match_count, head.match_position});

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_nxt1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + FIFO_CW'(push.count) - FIFO_CW'(pop);
		end
	end

endmodule

// ----- design/sliding_pattern_match.sv -----
// Top level of the streaming pattern matcher: input stage, window, compare and result queue.
//
// Items enter on the s_ channel. An item with s_tuser low loads s_tdata[35:4] into the
// pattern slot s_tdata[3:0]; an item with s_tuser high is a text word that shifts into the
// window. When the newest pattern_length text words equal the pattern, a match report
// (m_tuser low) carries the start position and the running count. A text word with s_tlast
// high also yields a summary item (m_tuser high) with the final count, after which the
// window, index and count return to zero; the patterns and the length are kept.
// The user must write pattern_length through cfg_wr_en and cfg_wr_data only while the block is idle;
// the block itself does not enforce it. An item is registered in the input stage on acceptance and
// compared there once the result queue has room; its results go into the queue, which drives the
// m_ channel, and a summary follows its report. One item is accepted every cycle while there is room; the
// input stage advances only while the four-entry result queue has room for two items, so a
// stalled receiver holds the queue and then the input stage, and nothing is lost.
// Reset empties the queue and the input stage, clears the text state and sets the length
// to one; pattern slots hold no defined value until they are written.
module sliding_pattern_match (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [spm_pkg::LEN_W-1:0]      cfg_wr_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [spm_pkg::S_TDATA_W-1:0]  s_tdata,   // slot, value
	input  logic                           s_tuser,   // kind
	input  logic                           s_tlast,   // is_last
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [spm_pkg::M_TDATA_W-1:0]  m_tdata,   // match_position, match_count
	output logic                           m_tuser    // is_done
);
	import spm_pkg::*;

	logic                                 valid_s1;
	logic                                 kind_s1;
	logic [SLOT_W-1:0]                    slot_s1;
	logic signed [VALUE_W-1:0]            value_s1;
	logic                                 last_s1;

	logic [LEN_W-1:0]                     len_cfg_q;
	logic [PATTERN_MAX-1:0][VALUE_W-1:0]  pattern_q;
	logic [PATTERN_MAX-1:0][VALUE_W-1:0]  window_q;
	logic [IDX_W-1:0]                     text_idx_q;
	logic [CNT_W-1:0]                     matches_q;

	logic                                 room;
	logic                                 proc_s1;
	logic                                 text_go;
	logic [LEN_W-1:0]                     len_eff;
	logic [PATTERN_MAX-1:0][VALUE_W-1:0]  window_new;
	logic [PATTERN_MAX-1:0]               slot_ok;
	logic [LEN_W-1:0]                     pidx;
	logic [IDX_W:0]                       idx_p1;
	logic [IDX_W:0]                       start_full;
	logic                                 hit;
	logic [CNT_W-1:0]                     count_nxt;
	logic [POS_W-1:0]                     start_pos;
	result_t                              rep_res;
	result_t                              sum_res;
	push_t                                push;

	assign proc_s1  = valid_s1 && room;
	assign s_tready = !valid_s1 || proc_s1;
	assign text_go  = proc_s1 && (kind_s1 == KIND_TEXT);

	always_comb begin
		len_eff = len_cfg_q;
		if (len_cfg_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (len_cfg_q > LEN_W'(PATTERN_MAX)) begin
			len_eff = LEN_W'(PATTERN_MAX);
		end

		window_new = {window_q[PATTERN_MAX-2:0], value_s1};

		for (int k = 0; k < PATTERN_MAX; k++) begin
			pidx = len_eff - LEN_W'(1) - LEN_W'(k);
			slot_ok[k] = (LEN_W'(k) >= len_eff) ||
				(window_new[k] == pattern_q[PIDX_W'(pidx)]);
		end

		idx_p1     = {1'b0, text_idx_q} + (IDX_W + 1)'(1);
		start_full = idx_p1 - (IDX_W + 1)'(len_eff);
		hit        = (idx_p1 >= (IDX_W + 1)'(len_eff)) && (&slot_ok);

		if (start_full > (IDX_W + 1)'(POS_SAT)) begin
			start_pos = POS_SAT;
		end else begin
			start_pos = start_full[POS_W-1:0];
		end

		count_nxt = matches_q;
		if (hit && (matches_q != CNT_SAT)) begin
			count_nxt = matches_q + CNT_W'(1);
		end

		rep_res.is_done        = 1'b0;
		rep_res.match_position = start_pos;
		rep_res.match_count    = count_nxt;
		sum_res.is_done        = 1'b1;
		sum_res.match_position = '0;
		sum_res.match_count    = count_nxt;

		push.count  = 2'd0;
		push.first  = rep_res;
		push.second = sum_res;
		if (text_go) begin
			if (hit && last_s1) begin
				push.count = 2'd2;
			end else if (hit) begin
				push.count = 2'd1;
			end else if (last_s1) begin
				push.count = 2'd1;
				push.first = sum_res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1  <= s_tuser;
			slot_s1  <= s_tdata[SLOT_W-1:0];
			value_s1 <= s_tdata[SLOT_W+VALUE_W-1:SLOT_W];
			last_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_s1 && (kind_s1 == KIND_PATTERN) && (int'(slot_s1) < PATTERN_MAX)) begin
			pattern_q[PIDX_W'(slot_s1)] <= value_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q  <= LEN_W'(1);
			window_q   <= '0;
			text_idx_q <= '0;
			matches_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				len_cfg_q <= cfg_wr_data;
			end
			if (text_go) begin
				if (last_s1) begin
					window_q   <= '0;
					text_idx_q <= '0;
					matches_q  <= '0;
				end else begin
					window_q  <= window_new;
					matches_q <= count_nxt;
					if (text_idx_q < IDX_W'(TEXT_MAX)) begin
						text_idx_q <= text_idx_q + IDX_W'(1);
					end
				end
			end
		end
	end

	spm_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

	// A summary item leaves the text state cleared for the next array.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(text_go && last_s1) |=> (text_idx_q == '0 && matches_q == '0 && window_q == '0))
		else $error("text state not cleared after the last text item");

	// A waiting input item keeps its contents until the compare stage takes it.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !proc_s1) |=> (valid_s1 && $stable(value_s1) && $stable(kind_s1)))
		else $error("input stage changed while it waited");

	// A match report always counts at least the match it reports.
	a_report_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[POS_W+CNT_W-1:POS_W] != '0))
		else $error("match report with a count of zero");

endmodule
